>>> hw/rtl/rce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rce_pkg
// shared types and constants of the reversible circuit evaluator
// ----------------------------------------------------------------------------
package rce_pkg;

  // default sizes of the gate row
  localparam int unsigned MaxGatesDef = 32;
  localparam int unsigned MaxLinesDef = 8;

  // register reset values and the match count ceiling
  localparam logic [5:0]  NumGatesRst = 6'd4;
  localparam logic [3:0]  NumLinesRst = 4'd3;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  // command codes
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EVAL  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // gate codes, one per gate and line
  typedef enum logic [1:0] {
    CODE_ZERO   = 2'd0,
    CODE_ONE    = 2'd1,
    CODE_PASS   = 2'd2,
    CODE_TARGET = 2'd3
  } gate_code_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_NUM_GATES = 1'b0,
    CFG_NUM_LINES = 1'b1
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic [1:0] action;
    logic [4:0] gate_index;
    logic [2:0] line_index;
    logic [1:0] gate_code;
    logic [7:0] input_pattern;
    logic [7:0] expected_pattern;
  } in_t;

  // result beat
  typedef struct packed {
    logic [7:0]  result_pattern;
    logic        matched;
    logic [15:0] match_count;
    logic [5:0]  active_gates;
  } out_t;

  // table write broadcast to the cells
  typedef struct packed {
    logic       en;
    logic [4:0] gate;
    logic [2:0] line;
    logic [1:0] code;
  } wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/rce_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rce_cell
// one gate of the cascade: holds its line codes, applies the gate to the
// pattern from its left neighbor and hands the result to the right
// ----------------------------------------------------------------------------
module rce_cell import rce_pkg::*; #(
  parameter int unsigned GateIdx  = 0,
  parameter int unsigned MaxGates = MaxGatesDef,
  parameter int unsigned MaxLines = MaxLinesDef,
  localparam int unsigned NGW = $clog2(MaxGates + 1),
  localparam int unsigned NLW = $clog2(MaxLines + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wr_t                 wr_i,
  input  wire logic [NGW-1:0]      ng_i,
  input  wire logic [NLW-1:0]      nl_i,
  input  wire logic [MaxLines-1:0] pat_i,
  input  wire logic [NGW-1:0]      cnt_i,
  output logic      [MaxLines-1:0] pat_o,
  output logic      [NGW-1:0]      cnt_o
);

  localparam int unsigned PW = (MaxLines > 1) ? $clog2(MaxLines) : 1;

  logic [MaxLines-1:0][1:0] code_q;
  logic [MaxLines-1:0]      pat_d;
  logic [NGW-1:0]           cnt_d;
  logic                     fire;
  logic                     has_tgt;
  logic [PW-1:0]            tgt_pos;
  logic                     gate_on;

  // code storage, written by broadcast
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MaxLines; l++) begin
        code_q[l] <= CODE_PASS;
      end
    end else if (wr_i.en && (32'(wr_i.gate) == GateIdx)) begin
      for (int l = 0; l < MaxLines; l++) begin
        if (32'(wr_i.line) == l) begin
          code_q[l] <= wr_i.code;
        end
      end
    end
  end

  // control match and target pick, highest line wins
  always_comb begin
    logic [PW-1:0] pos;
    fire    = 1'b1;
    has_tgt = 1'b0;
    tgt_pos = '0;
    pos     = '0;
    for (int l = 0; l < MaxLines; l++) begin
      if (32'(nl_i) > l) begin
        pos = PW'(32'(nl_i) - 32'(l) - 1);
        case (code_q[l])
          CODE_ZERO, CODE_ONE: begin
            if (pat_i[pos] != code_q[l][0]) begin
              fire = 1'b0;
            end
          end
          CODE_TARGET: begin
            has_tgt = 1'b1;
            tgt_pos = pos;
          end
          default: ;
        endcase
      end
    end
  end

  assign gate_on = (32'(ng_i) > GateIdx);

  always_comb begin
    pat_d = pat_i;
    if (gate_on && fire && has_tgt) begin
      pat_d[tgt_pos] = ~pat_i[tgt_pos];
    end
    cnt_d = cnt_i + NGW'(gate_on && has_tgt);
  end

  always_ff @(posedge clk_i) begin
    pat_o <= pat_d;
    cnt_o <= cnt_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/reversible_circuit_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_circuit_evaluator
// mixed-polarity toffoli cascade evaluator built as a row of gate cells
// ----------------------------------------------------------------------------
// A command beat is taken when start_i is high and busy_o is low. Every
// command (write a gate code, evaluate a pattern, clear the match count)
// yields exactly one result beat on out_o, marked by out_valid_o for one
// cycle; the receiver cannot stall it, so it must sample on that cycle.
// The beat walks the row of MaxGates cells, one cell per cycle, and each
// cell applies its own gate and adds its target flag to the active count.
// A new command may be taken in the cycle the result is shown. Table
// writes land at the accept edge, so the result of a write already
// counts the new code. Configuration writes are only valid while
// busy_o is low.
// ----------------------------------------------------------------------------
module reversible_circuit_evaluator import rce_pkg::*; #(
  parameter int unsigned MaxGates = MaxGatesDef,
  parameter int unsigned MaxLines = MaxLinesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // command channel
  input  wire logic       start_i,
  input  wire in_t        in_i,
  output logic            busy_o,
  // result channel
  output logic            out_valid_o,
  output out_t            out_o,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [5:0] cfg_data_i
);

  localparam int unsigned NGW = $clog2(MaxGates + 1);
  localparam int unsigned NLW = $clog2(MaxLines + 1);
  localparam int unsigned SW  = $clog2(MaxGates + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [SW-1:0]        step_q, step_d;
  logic [5:0]           num_gates_q;
  logic [3:0]           num_lines_q;
  logic [15:0]          count_q;
  logic [1:0]           act_q;
  logic [MaxLines-1:0]  exp_q;
  logic [MaxLines-1:0]  pat0_q;
  out_t                 out_q;

  logic                 accept;
  logic                 last_step;
  logic [NGW-1:0]       ng_eff;
  logic [NLW-1:0]       nl_eff;
  logic [MaxLines-1:0]  mask;
  logic                 matched;
  logic [15:0]          count_next;
  wr_t                  wr;

  // chain taps: entry at index 0, cell g drives index g+1
  logic [MaxLines-1:0]  pat_w [MaxGates+1];
  logic [NGW-1:0]       cnt_w [MaxGates+1];

  assign accept = start_i && !busy_o;
  // a result beat may overlap the next accept
  assign busy_o = (state_q == ST_RUN);

  // saturate the configuration to the row size
  assign ng_eff = (32'(num_gates_q) > MaxGates) ? NGW'(MaxGates) : NGW'(num_gates_q);
  assign nl_eff = (32'(num_lines_q) > MaxLines) ? NLW'(MaxLines) : NLW'(num_lines_q);

  // live lines of the pattern
  always_comb begin
    for (int l = 0; l < MaxLines; l++) begin
      mask[l] = (32'(nl_eff) > l);
    end
  end

  // table write goes straight into the cells
  always_comb begin
    wr.en   = accept && (in_i.action == ACT_WRITE);
    wr.gate = in_i.gate_index;
    wr.line = in_i.line_index;
    wr.code = in_i.gate_code;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_gates_q <= NumGatesRst;
      num_lines_q <= NumLinesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_GATES: num_gates_q <= cfg_data_i;
        CFG_NUM_LINES: num_lines_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // entry stage: masked patterns and the command held for the whole walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_i.action;
      pat0_q <= MaxLines'(in_i.input_pattern) & mask;
      exp_q  <= MaxLines'(in_i.expected_pattern) & mask;
    end
  end

  assign pat_w[0] = pat0_q;
  assign cnt_w[0] = '0;

  // the row of gate cells
  for (genvar g = 0; g < MaxGates; g++) begin : g_cell
    rce_cell #(
      .GateIdx  (g),
      .MaxGates (MaxGates),
      .MaxLines (MaxLines)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .ng_i   (ng_eff),
      .nl_i   (nl_eff),
      .pat_i  (pat_w[g]),
      .cnt_i  (cnt_w[g]),
      .pat_o  (pat_w[g+1]),
      .cnt_o  (cnt_w[g+1])
    );
  end

  // last cell output is settled once step reaches the row length
  assign last_step = (state_q == ST_RUN) && (step_q == SW'(MaxGates));

  assign matched = (act_q == ACT_EVAL) && (pat_w[MaxGates] == exp_q);
  assign count_next = (matched && (count_q != CountMax)) ? count_q + 16'd1 : count_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + SW'(1);
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // match counter: clear when a clear command is accepted, bump when the walk ends on a match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && (in_i.action == ACT_CLEAR)) begin
      count_q <= '0;
    end else if (last_step) begin
      count_q <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (last_step) begin
      out_q.result_pattern <= (act_q == ACT_EVAL) ? 8'(pat_w[MaxGates]) : 8'd0;
      out_q.matched        <= matched;
      out_q.match_count    <= count_next;
      out_q.active_gates   <= 6'(cnt_w[MaxGates]);
    end
  end

  assign out_valid_o = (state_q == ST_DONE);
  assign out_o       = out_q;

  // accepted command starts a walk
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN))
    else $error("accepted command did not start a walk");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  // step counter stays within the row
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= SW'(MaxGates)))
    else $error("step counter ran past the row");

  // match counter only falls on a clear
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && (in_i.action == ACT_CLEAR)) |=> (count_q >= $past(count_q)))
    else $error("match counter fell without a clear");

  // a match flag only comes from an evaluate
  a_match_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.matched) |-> (act_q == ACT_EVAL))
    else $error("match flag on a non-evaluate beat");

endmodule

`default_nettype wire

>>> dv/tb_reversible_circuit_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_reversible_circuit_evaluator
// self-checking testbench of the toffoli cascade evaluator
// ----------------------------------------------------------------------------
// The bench drives command beats with random gaps and checks every result
// beat against a cascade predictor in a small scoreboard class. A short
// directed run covers polarity of the controls, competing targets, unused
// pattern bits, clears and the unused command code. Random phases follow:
// each one waits for the block to drain, writes both size registers
// (extremes and out-of-range values included) and then mixes gate writes,
// evaluations (half of them aimed to match), clears and noise commands.
// ----------------------------------------------------------------------------
module tb_reversible_circuit_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  import rce_pkg::*;

  // command code that the block does not define, answered like a write
  localparam logic [1:0] ActUnused = 2'd3;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned PhaseBeats = 90;

  // predictor of the cascade plus the queue of result beats still due
  class cascade_scoreboard;
    gate_code_e  codes [MaxGatesDef][MaxLinesDef];
    logic [15:0] hits;
    logic [5:0]  gates_cfg;
    logic [3:0]  lines_cfg;
    out_t        due_results[$];
    int unsigned errors;

    function new();
      foreach (codes[g, l]) codes[g][l] = CODE_PASS;
      hits      = '0;
      gates_cfg = NumGatesRst;
      lines_cfg = NumLinesRst;
      errors    = 0;
    endfunction

    function void set_config(cfg_idx_e idx, logic [5:0] value);
      if (idx == CFG_NUM_GATES) gates_cfg = value;
      else lines_cfg = value[3:0];
    endfunction

    // sizes saturate at the table dimensions
    function int unsigned eff_gates();
      return (32'(gates_cfg) > MaxGatesDef) ? MaxGatesDef : 32'(gates_cfg);
    endfunction

    function int unsigned eff_lines();
      return (32'(lines_cfg) > MaxLinesDef) ? MaxLinesDef : 32'(lines_cfg);
    endfunction

    function logic [7:0] line_mask(int unsigned nl);
      logic [15:0] m;
      m = (16'd1 << nl) - 16'd1;
      return m[7:0];
    endfunction

    // line 0 is the msb of the low nl bits; the last target of a gate wins
    function logic [7:0] apply_cascade(logic [7:0] pat);
      int unsigned ng, nl, tgt;
      bit          fire, has_tgt;
      logic [7:0]  p;
      ng = eff_gates();
      nl = eff_lines();
      p  = pat & line_mask(nl);
      for (int unsigned g = 0; g < ng; g++) begin
        fire    = 1'b1;
        has_tgt = 1'b0;
        tgt     = 0;
        for (int unsigned l = 0; l < nl; l++) begin
          case (codes[g][l])
            CODE_ZERO:   if (p[nl-1-l] != 1'b0) fire = 1'b0;
            CODE_ONE:    if (p[nl-1-l] != 1'b1) fire = 1'b0;
            CODE_TARGET: begin
              has_tgt = 1'b1;
              tgt     = l;
            end
            default: ;
          endcase
        end
        if (fire && has_tgt) p[nl-1-tgt] = ~p[nl-1-tgt];
      end
      return p & line_mask(nl);
    endfunction

    function logic [5:0] count_targets();
      int unsigned n;
      bit          hit;
      n = 0;
      for (int unsigned g = 0; g < eff_gates(); g++) begin
        hit = 1'b0;
        for (int unsigned l = 0; l < eff_lines(); l++) hit |= (codes[g][l] == CODE_TARGET);
        if (hit) n++;
      end
      return n[5:0];
    endfunction

    // accepted command beat: update the state and queue its result
    function void note_command(in_t c);
      out_t want;
      want = '0;
      case (c.action)
        ACT_WRITE: codes[c.gate_index][c.line_index] = gate_code_e'(c.gate_code);
        ACT_EVAL: begin
          want.result_pattern = apply_cascade(c.input_pattern);
          if (want.result_pattern == (c.expected_pattern & line_mask(eff_lines()))) begin
            want.matched = 1'b1;
            if (hits != CountMax) hits++;
          end
        end
        ACT_CLEAR: hits = '0;
        default: ;
      endcase
      want.match_count  = hits;
      want.active_gates = count_targets();
      due_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_beat(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("result_pattern", 16'(want.result_pattern), 16'(got.result_pattern));
      compare_field("matched", 16'(want.matched), 16'(got.matched));
      compare_field("match_count", want.match_count, got.match_count);
      compare_field("active_gates", 16'(want.active_gates), 16'(got.active_gates));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  in_t        in_i;
  logic       busy_o;
  logic       out_valid_o;
  out_t       out_o;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [5:0] cfg_data_i;

  cascade_scoreboard sb;
  int unsigned       accepted = 0;  // command beats taken by the block so far

  reversible_circuit_evaluator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample at the rising edge: the result leaving first, then the command
  // taken on the same edge, since a new beat may enter as a result leaves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o) sb.check_beat(out_o);
      if (start_i && !busy_o) begin
        sb.note_command(in_i);
        accepted++;
      end
    end
  end

  // watchdog, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_t make_cmd(logic [1:0] act, logic [4:0] gi, logic [2:0] li,
                                   gate_code_e code, logic [7:0] ip, logic [7:0] ep);
    in_t c;
    c.action           = act;
    c.gate_index       = gi;
    c.line_index       = li;
    c.gate_code        = code;
    c.input_pattern    = ip;
    c.expected_pattern = ep;
    return c;
  endfunction

  // random command; writes mostly land inside the active part of the table
  // and half the evaluations carry the predicted result so matches are common
  function automatic in_t random_cmd();
    in_t         c;
    int unsigned pick, ng, nl;
    logic [7:0]  mask;
    c    = in_t'($urandom);
    ng   = sb.eff_gates();
    nl   = sb.eff_lines();
    mask = sb.line_mask(nl);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.action = ACT_WRITE;
      if (ng != 0 && $urandom_range(0, 4) != 0) c.gate_index = 5'($urandom_range(0, ng - 1));
      if (nl != 0 && $urandom_range(0, 4) != 0) c.line_index = 3'($urandom_range(0, nl - 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c.gate_code = CODE_PASS;
        4, 5:       c.gate_code = CODE_TARGET;
        6, 7:       c.gate_code = CODE_ZERO;
        default:    c.gate_code = CODE_ONE;
      endcase
    end else if (pick < 88) begin
      c.action = ACT_EVAL;
      if ($urandom_range(0, 1) == 1)
        c.expected_pattern = sb.apply_cascade(c.input_pattern) | (c.expected_pattern & ~mask);
    end else if (pick < 96) begin
      c.action = ACT_CLEAR;
    end else begin
      c.action = ActUnused;
    end
    return c;
  endfunction

  // hold the beat until the block takes it; returns on the next falling edge
  task automatic push_cmd(in_t c);
    int unsigned seen;
    seen = accepted;
    start_i <= 1'b1;
    in_i    <= c;
    do @(negedge clk_i); while (accepted == seen);
  endtask

  // sender gap, sometimes placed right after the block turns ready
  task automatic idle_burst();
    start_i <= 1'b0;
    in_i    <= in_t'($urandom);
    if ($urandom_range(0, 1) == 1) while (busy_o) @(negedge clk_i);
    repeat ($urandom_range(1, 19)) @(negedge clk_i);
  endtask

  // stop sending until every result has come back and the block is ready
  task automatic wait_quiet();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.due_results.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [5:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    sb.set_config(idx, value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= 1'($urandom);
    cfg_data_i <= 6'($urandom);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned gates_set [4] = '{32, 1, 0, 63};
    int unsigned lines_set [4] = '{8, 1, 0, 15};
    int unsigned ng, nl;

    sb         = new();
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    in_i       = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset sizes: 4 gates on 3 lines, table all pass
    // bits above the active lines are ignored on both patterns
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'hFF, 8'h07));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'h00, 8'hF8));
    // gate 0: one-control on line 0, zero-control on line 1, target on line 2
    push_cmd(make_cmd(ACT_WRITE, 5'd0, 3'd0, CODE_ONE, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_WRITE, 5'd0, 3'd1, CODE_ZERO, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_WRITE, 5'd0, 3'd2, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'b100, 8'b101));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'b110, 8'b110));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'b000, 8'b111));
    // gate 1 holds two targets with no control: the higher line flips
    push_cmd(make_cmd(ACT_WRITE, 5'd1, 3'd0, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_WRITE, 5'd1, 3'd1, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'h00, 8'b010));
    // target in the last active gate, and one beyond the active gates
    push_cmd(make_cmd(ACT_WRITE, 5'd3, 3'd2, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_WRITE, 5'd4, 3'd0, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'hFF, 8'hFF));
    // target on a line outside the active lines is not counted
    push_cmd(make_cmd(ACT_WRITE, 5'd2, 3'd7, CODE_TARGET, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_WRITE, 5'd31, 3'd7, CODE_ONE, 8'hFF, 8'hFF));
    push_cmd(make_cmd(ACT_EVAL, 5'd31, 3'd7, CODE_TARGET, 8'hA5, 8'h5A));
    // noise fields on clear and on the unused code
    push_cmd(make_cmd(ACT_CLEAR, 5'd31, 3'd7, CODE_TARGET, 8'hFF, 8'hFF));
    push_cmd(make_cmd(ActUnused, 5'd5, 3'd1, CODE_TARGET, 8'hFF, 8'h00));
    push_cmd(make_cmd(ACT_EVAL, 5'd0, 3'd0, CODE_PASS, 8'h03, 8'h00));

    // random phases, sizes set while the block is drained
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      wait_quiet();
      if (p < 4) begin
        ng = gates_set[p];
        nl = lines_set[p];
      end else begin
        ng = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
        nl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      end
      write_reg(CFG_NUM_GATES, ng[5:0]);
      // upper data bits do not belong to the line count
      write_reg(CFG_NUM_LINES, {2'($urandom), nl[3:0]});
      for (int unsigned i = 0; i < PhaseBeats; i++) begin
        // the closing phases run back to back
        if (p < PhaseCount - 2 && $urandom_range(0, 3) == 0) idle_burst();
        push_cmd(random_cmd());
      end
    end

    wait_quiet();
    // catch stray result beats
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> reversible_circuit_evaluator.f
hw/rtl/rce_pkg.sv
hw/rtl/rce_cell.sv
hw/rtl/reversible_circuit_evaluator.sv
dv/tb_reversible_circuit_evaluator.sv
